// ===== rtl/bts_pkg.sv =====
`default_nettype none

package bts_pkg;

   localparam int COORD_W   = 16;
   localparam int SIZE_W    = 7;
   localparam int TEXEL_X_W = 6;
   localparam int TEXEL_Y_W = 6;
   localparam int RGBA_W    = 32;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int NUM_BANKS = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIZE_W-1:0] TEXTURE_WIDTH_RESET  = 7'd64;
   localparam logic [SIZE_W-1:0] TEXTURE_HEIGHT_RESET = 7'd64;
   localparam logic [RGBA_W-1:0] TINT_RGBA_RESET      = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXTURE_WIDTH  = 2'd0,
      CSR_TEXTURE_HEIGHT = 2'd1,
      CSR_TINT_RGBA      = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/bts_req_if.sv =====
`default_nettype none

interface bts_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [bts_pkg::TEXEL_X_W-1:0]  texel_x;
   logic [bts_pkg::TEXEL_Y_W-1:0]  texel_y;
   logic [bts_pkg::RGBA_W-1:0]     texel_rgba;
   logic [bts_pkg::COORD_W-1:0]    u_coord;
   logic [bts_pkg::COORD_W-1:0]    v_coord;

   modport source (
      output valid, operation, texel_x, texel_y, texel_rgba, u_coord, v_coord,
      input  ready
   );

   modport sink (
      input  valid, operation, texel_x, texel_y, texel_rgba, u_coord, v_coord,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/bts_rsp_if.sv =====
`default_nettype none

interface bts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bts_pkg::RGBA_W-1:0] sample_rgba;

   modport source (
      output valid, sample_rgba,
      input  ready
   );

   modport sink (
      input  valid, sample_rgba,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/bilinear_texture_sampler.sv =====
// a sample passes the accept, address, horizontal lerp, vertical lerp, tint and divide registers
// throughput: one request per cycle unless the output stalls; four parity banks give the neighbours in one read
// a texel write takes effect in the cycle after acceptance and gives no response
// reset clears the pipeline valids and sets width 64, height 64 and tint to all ones
// the texture banks are not cleared by reset; entries are undefined until written
`default_nettype none

module bilinear_texture_sampler #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   bts_req_if.sink                             req_bus,
   bts_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [bts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SIZE_W   = bts_pkg::SIZE_W;
   localparam int COORD_W  = bts_pkg::COORD_W;
   localparam int CHAN_W   = bts_pkg::CHAN_W;
   localparam int NUM_CHAN = bts_pkg::NUM_CHAN;
   localparam int RGBA_W   = bts_pkg::RGBA_W;
   localparam int NBANK    = bts_pkg::NUM_BANKS;

   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int XAW        = (HALF_W > 1) ? $clog2(HALF_W) : 1;
   localparam int YAW        = (HALF_H > 1) ? $clog2(HALF_H) : 1;
   localparam int BANK_AW    = XAW + YAW;
   localparam int BANK_DEPTH = 2 ** BANK_AW;

   localparam int MUL_W   = COORD_W + SIZE_W;
   localparam int SHIFT   = COORD_W - FRAC_BITS;
   localparam int POS_W   = MUL_W - SHIFT + 1;
   localparam int RND     = 1 << (SHIFT - 1);
   localparam int HALF    = 1 << (FRAC_BITS - 1);
   localparam int SCALE   = 1 << FRAC_BITS;
   localparam int WGT_W   = FRAC_BITS + 1;
   localparam int HW      = CHAN_W + FRAC_BITS;
   localparam int VW      = CHAN_W + 2 * FRAC_BITS;
   localparam int HALF_SQ = 1 << (2 * FRAC_BITS - 1);
   localparam int PROD_W  = 2 * CHAN_W;

   typedef struct packed {
      logic [SIZE_W-1:0]    idx;
      logic [FRAC_BITS-1:0] frac;
      logic                 single;
   } axis_type;

   typedef struct packed {
      bts_pkg::op_type               op;
      logic [bts_pkg::TEXEL_X_W-1:0] x;
      logic [bts_pkg::TEXEL_Y_W-1:0] y;
      logic [RGBA_W-1:0]             rgba;
      logic [MUL_W-1:0]              pu;
      logic [MUL_W-1:0]              pv;
   } s1_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] ty;
      logic                 px;
      logic                 py;
      logic                 onex;
      logic                 oney;
   } s2_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][HW-1:0] top;
      logic [NUM_CHAN-1:0][HW-1:0] bot;
      logic [FRAC_BITS-1:0]        ty;
   } s3_type;

   // configuration
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [RGBA_W-1:0] tint_ff, tint_in;
   logic [SIZE_W-1:0] eff_w, eff_h;

   // pipeline
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic s4_v_ff, s4_v_in, s5_v_ff, s5_v_in, out_v_ff, out_v_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] s4_ff, s4_in;
   logic [NUM_CHAN-1:0][PROD_W-1:0] s5_ff, s5_in;
   logic [RGBA_W-1:0] out_ff, out_in;
   logic en1, en2, en3, en4, en5, en_out, s1_sample, s1_leave;

   // texture banks
   logic [RGBA_W-1:0]  bank_mem [NBANK][BANK_DEPTH];
   logic [RGBA_W-1:0]  bank_q_ff [NBANK];
   logic [BANK_AW-1:0] rd_addr [NBANK];
   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;
   logic               wr_en;
   axis_type           ax_u, ax_v;

   function automatic axis_type map_axis(input logic [MUL_W-1:0] prod,
                                         input logic [SIZE_W-1:0] size);
      logic [MUL_W:0]  rnd;
      logic [POS_W-1:0] raw;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] hi;
      axis_type         res;
      rnd = {1'b0, prod} + (MUL_W + 1)'(RND);
      raw = rnd[MUL_W:SHIFT];
      pos = (raw > POS_W'(HALF)) ? raw - POS_W'(HALF) : '0;
      hi  = (POS_W'(size - SIZE_W'(1)) << FRAC_BITS) - POS_W'(1);
      if (pos > hi) begin
         pos = hi;
      end
      res.idx    = pos[FRAC_BITS +: SIZE_W];
      res.frac   = pos[FRAC_BITS-1:0];
      res.single = 1'b0;
      if (size <= SIZE_W'(1)) begin
         res.idx    = '0;
         res.frac   = '0;
         res.single = 1'b1;
      end
      return res;
   endfunction

   // sizes saturate at the store dimensions
   assign eff_w = (32'(width_ff) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign eff_h = (32'(height_ff) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      tint_in   = tint_ff;
      if (csr_we) begin
         unique case (bts_pkg::csr_index_type'(csr_index))
            bts_pkg::CSR_TEXTURE_WIDTH: begin
               width_in = csr_wdata[SIZE_W-1:0];
            end
            bts_pkg::CSR_TEXTURE_HEIGHT: begin
               height_in = csr_wdata[SIZE_W-1:0];
            end
            bts_pkg::CSR_TINT_RGBA: begin
               tint_in = csr_wdata[RGBA_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // stall chain, bubbles collapse
   assign en_out    = !out_v_ff || rsp_bus.ready;
   assign en5       = !s5_v_ff || en_out;
   assign en4       = !s4_v_ff || en5;
   assign en3       = !s3_v_ff || en4;
   assign en2       = !s2_v_ff || en3;
   assign s1_sample = (s1_ff.op == bts_pkg::OP_SAMPLE);
   assign s1_leave  = s1_sample ? en2 : 1'b1;
   assign en1       = !s1_v_ff || s1_leave;
   assign req_bus.ready = en1;

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.sample_rgba = out_ff;

   assign s1_v_in  = en1 ? req_bus.valid : s1_v_ff;
   assign s2_v_in  = en2 ? (s1_v_ff && s1_sample) : s2_v_ff;
   assign s3_v_in  = en3 ? s2_v_ff : s3_v_ff;
   assign s4_v_in  = en4 ? s3_v_ff : s4_v_ff;
   assign s5_v_in  = en5 ? s4_v_ff : s5_v_ff;
   assign out_v_in = en_out ? s5_v_ff : out_v_ff;

   // accept: scale coordinates by size
   always_comb begin
      s1_in.op   = bts_pkg::op_type'(req_bus.operation);
      s1_in.x    = req_bus.texel_x;
      s1_in.y    = req_bus.texel_y;
      s1_in.rgba = req_bus.texel_rgba;
      s1_in.pu   = MUL_W'(req_bus.u_coord) * MUL_W'(eff_w);
      s1_in.pv   = MUL_W'(req_bus.v_coord) * MUL_W'(eff_h);
   end

   // address stage: clamp, neighbours, bank addresses, texel write
   always_comb begin
      logic [SIZE_W-1:0] x1, y1, xe, xo, ye, yo;
      ax_u = map_axis(s1_ff.pu, eff_w);
      ax_v = map_axis(s1_ff.pv, eff_h);
      x1 = ax_u.idx + SIZE_W'(1);
      y1 = ax_v.idx + SIZE_W'(1);
      xe = ax_u.idx[0] ? x1 : ax_u.idx;
      xo = ax_u.idx[0] ? ax_u.idx : x1;
      ye = ax_v.idx[0] ? y1 : ax_v.idx;
      yo = ax_v.idx[0] ? ax_v.idx : y1;
      rd_addr[0] = {YAW'(ye[SIZE_W-1:1]), XAW'(xe[SIZE_W-1:1])};
      rd_addr[1] = {YAW'(ye[SIZE_W-1:1]), XAW'(xo[SIZE_W-1:1])};
      rd_addr[2] = {YAW'(yo[SIZE_W-1:1]), XAW'(xe[SIZE_W-1:1])};
      rd_addr[3] = {YAW'(yo[SIZE_W-1:1]), XAW'(xo[SIZE_W-1:1])};

      s2_in.tx   = ax_u.frac;
      s2_in.ty   = ax_v.frac;
      s2_in.px   = ax_u.idx[0];
      s2_in.py   = ax_v.idx[0];
      s2_in.onex = ax_u.single;
      s2_in.oney = ax_v.single;

      wr_en   = s1_v_ff && !s1_sample && (32'(s1_ff.x) < MAX_WIDTH)
                && (32'(s1_ff.y) < MAX_HEIGHT);
      wr_bank = {s1_ff.y[0], s1_ff.x[0]};
      wr_addr = {YAW'(s1_ff.y[bts_pkg::TEXEL_Y_W-1:1]),
                 XAW'(s1_ff.x[bts_pkg::TEXEL_X_W-1:1])};
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NBANK; b++) begin
         if (wr_en && wr_bank == 2'(b)) begin
            bank_mem[b][wr_addr] <= s1_ff.rgba;
         end
         if (en2) begin
            bank_q_ff[b] <= bank_mem[b][rd_addr[b]];
         end
      end
   end

   // horizontal lerp
   always_comb begin
      logic [RGBA_W-1:0] p00, p10, p01, p11;
      logic [WGT_W-1:0]  wx;
      p00 = s2_ff.py ? (s2_ff.px ? bank_q_ff[3] : bank_q_ff[2])
                     : (s2_ff.px ? bank_q_ff[1] : bank_q_ff[0]);
      p10 = s2_ff.py ? (s2_ff.px ? bank_q_ff[2] : bank_q_ff[3])
                     : (s2_ff.px ? bank_q_ff[0] : bank_q_ff[1]);
      p01 = s2_ff.py ? (s2_ff.px ? bank_q_ff[1] : bank_q_ff[0])
                     : (s2_ff.px ? bank_q_ff[3] : bank_q_ff[2]);
      p11 = s2_ff.py ? (s2_ff.px ? bank_q_ff[0] : bank_q_ff[1])
                     : (s2_ff.px ? bank_q_ff[2] : bank_q_ff[3]);
      // single texel axes reuse texel zero
      if (s2_ff.onex) begin
         p10 = p00;
         p11 = p01;
      end
      if (s2_ff.oney) begin
         p01 = p00;
         p11 = p10;
      end
      wx = WGT_W'(SCALE) - {1'b0, s2_ff.tx};
      for (int c = 0; c < NUM_CHAN; c++) begin
         s3_in.top[c] = HW'(p00[c*CHAN_W +: CHAN_W]) * HW'(wx)
                      + HW'(p10[c*CHAN_W +: CHAN_W]) * HW'(s2_ff.tx);
         s3_in.bot[c] = HW'(p01[c*CHAN_W +: CHAN_W]) * HW'(wx)
                      + HW'(p11[c*CHAN_W +: CHAN_W]) * HW'(s2_ff.tx);
      end
      s3_in.ty = s2_ff.ty;
   end

   // vertical lerp with rounding
   always_comb begin
      logic [WGT_W-1:0] wy;
      logic [VW-1:0]    acc;
      wy = WGT_W'(SCALE) - {1'b0, s3_ff.ty};
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc = VW'(s3_ff.top[c]) * VW'(wy) + VW'(s3_ff.bot[c]) * VW'(s3_ff.ty)
             + VW'(HALF_SQ);
         s4_in[c] = acc[2*FRAC_BITS +: CHAN_W];
      end
   end

   // tint product
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         s5_in[c] = PROD_W'(s4_ff[c]) * PROD_W'(tint_ff[c*CHAN_W +: CHAN_W])
                  + PROD_W'(127);
      end
   end

   // divide by 255; the output is zero when width or height is zero
   always_comb begin
      logic [PROD_W:0] q;
      out_in = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         q = {1'b0, s5_ff[c]} + (PROD_W + 1)'(s5_ff[c][PROD_W-1:CHAN_W])
           + (PROD_W + 1)'(1);
         out_in[c*CHAN_W +: CHAN_W] = q[CHAN_W +: CHAN_W];
      end
      if (eff_w == '0 || eff_h == '0) begin
         out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bts_pkg::TEXTURE_WIDTH_RESET;
         height_ff <= bts_pkg::TEXTURE_HEIGHT_RESET;
         tint_ff   <= bts_pkg::TINT_RGBA_RESET;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         tint_ff   <= tint_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         s3_v_ff   <= s3_v_in;
         s4_v_ff   <= s4_v_in;
         s5_v_ff   <= s5_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
      if (en5) begin
         s5_ff <= s5_in;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W    = bts_pkg::COORD_W;
   localparam int SIZE_W     = bts_pkg::SIZE_W;
   localparam int TEXEL_X_W  = bts_pkg::TEXEL_X_W;
   localparam int TEXEL_Y_W  = bts_pkg::TEXEL_Y_W;
   localparam int RGBA_W     = bts_pkg::RGBA_W;
   localparam int CHAN_W     = bts_pkg::CHAN_W;
   localparam int NUM_CHAN   = bts_pkg::NUM_CHAN;
   localparam int CSR_IDX_W  = bts_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = bts_pkg::CSR_DATA_W;

   localparam int TEX_MAX_W      = 64;
   localparam int TEX_MAX_H      = 64;
   localparam int TEX_FRAC       = 8;
   localparam int SAMPLE_LATENCY = 5;
   localparam int SETTLE_CYCLES  = SAMPLE_LATENCY + 4;
   localparam int PHASE_REQUESTS = 300;
   localparam int SCENE_REQUESTS = 40;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bts_req_if req_bus();
   bts_rsp_if rsp_bus();

   bilinear_texture_sampler #(
      .MAX_WIDTH (TEX_MAX_W),
      .MAX_HEIGHT(TEX_MAX_H),
      .FRAC_BITS (TEX_FRAC)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow copy of the texture store and registers
   logic [RGBA_W-1:0] texel_mem     [TEX_MAX_W*TEX_MAX_H];
   bit                texel_written [TEX_MAX_W*TEX_MAX_H];
   logic [SIZE_W-1:0] width_reg  = bts_pkg::TEXTURE_WIDTH_RESET;
   logic [SIZE_W-1:0] height_reg = bts_pkg::TEXTURE_HEIGHT_RESET;
   logic [RGBA_W-1:0] tint_reg   = bts_pkg::TINT_RGBA_RESET;
   logic [RGBA_W-1:0] expected_colours [$];

   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   int ready_hold_cycles = 0;
   int error_count       = 0;
   int requests_sent     = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("bilinear_texture_sampler regression: fail");
      $finish;
   end

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] sz,
                                              input int unsigned limit);
      return (sz > limit) ? limit : 32'(sz);
   endfunction

   // maps a normalised coordinate onto texel index pair and fraction
   function automatic void locate_axis(input logic [COORD_W-1:0] coord,
                                       input int unsigned size,
                                       output int unsigned i0,
                                       output int unsigned i1,
                                       output int unsigned frac);
      longint unsigned p, half, top;
      p = 64'(coord);
      p = (p * size + (64'd1 << (15 - TEX_FRAC))) >> (16 - TEX_FRAC);
      half = 64'd1 << (TEX_FRAC - 1);
      p = (p > half) ? p - half : 64'd0;
      if (size <= 1) begin
         i0 = 0;
         i1 = 0;
         frac = 0;
      end else begin
         top = (64'(size - 1) << TEX_FRAC) - 1;
         if (p > top)
            p = top;
         i0 = 32'(p >> TEX_FRAC);
         i1 = i0 + 1;
         frac = 32'(p & ((64'd1 << TEX_FRAC) - 1));
      end
   endfunction

   function automatic logic [RGBA_W-1:0] filtered_colour(input logic [COORD_W-1:0] u,
                                                         input logic [COORD_W-1:0] v);
      int unsigned       w, h, x0, x1, y0, y1, tx, ty;
      longint unsigned   s, top_row, bot_row, mixed, tint_ch, scaled;
      logic [RGBA_W-1:0] p00, p10, p01, p11, colour;
      w = clamp_size(width_reg, TEX_MAX_W);
      h = clamp_size(height_reg, TEX_MAX_H);
      if (w == 0 || h == 0)
         return '0;
      locate_axis(u, w, x0, x1, tx);
      locate_axis(v, h, y0, y1, ty);
      p00 = texel_mem[y0*TEX_MAX_W + x0];
      p10 = texel_mem[y0*TEX_MAX_W + x1];
      p01 = texel_mem[y1*TEX_MAX_W + x0];
      p11 = texel_mem[y1*TEX_MAX_W + x1];
      s = 64'd1 << TEX_FRAC;
      colour = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         top_row = 64'(p00[c*CHAN_W +: CHAN_W]) * (s - tx)
                 + 64'(p10[c*CHAN_W +: CHAN_W]) * tx;
         bot_row = 64'(p01[c*CHAN_W +: CHAN_W]) * (s - tx)
                 + 64'(p11[c*CHAN_W +: CHAN_W]) * tx;
         mixed = (top_row * (s - ty) + bot_row * ty + ((s * s) >> 1)) >> (2 * TEX_FRAC);
         if (mixed > 255)
            mixed = 255;
         tint_ch = 64'(tint_reg[c*CHAN_W +: CHAN_W]);
         scaled = (mixed * tint_ch + 127) / 255;
         colour[c*CHAN_W +: CHAN_W] = scaled[CHAN_W-1:0];
      end
      return colour;
   endfunction

   function automatic logic [RGBA_W-1:0] pick_rgba();
      logic [RGBA_W-1:0] val;
      case ($urandom_range(9))
         0: val = '0;
         1: val = '1;
         2, 3: begin
            for (int c = 0; c < NUM_CHAN; c++)
               val[c*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
         end
         default: val = $urandom();
      endcase
      return val;
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(19))
         0, 1:    return '0;
         2, 3:    return '1;
         4, 5:    return COORD_W'($urandom_range(1023));
         6, 7:    return COORD_W'($urandom_range(16'hFC00, 16'hFFFF));
         default: return COORD_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(19))
         0:       return '0;
         1, 2:    return SIZE_W'(1);
         3:       return SIZE_W'($urandom_range(TEX_MAX_W + 1, 127));
         4:       return SIZE_W'(TEX_MAX_W);
         5:       return SIZE_W'($urandom_range(32, TEX_MAX_W - 1));
         default: return SIZE_W'($urandom_range(2, 8));
      endcase
   endfunction

   task automatic send_request(input bts_pkg::op_type op,
                               input logic [TEXEL_X_W-1:0] x,
                               input logic [TEXEL_Y_W-1:0] y,
                               input logic [RGBA_W-1:0] rgba,
                               input logic [COORD_W-1:0] u,
                               input logic [COORD_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.texel_x    <= x;
      req_bus.texel_y    <= y;
      req_bus.texel_rgba <= rgba;
      req_bus.u_coord    <= u;
      req_bus.v_coord    <= v;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      requests_sent++;
      if (op == bts_pkg::OP_WRITE) begin
         texel_mem[y*TEX_MAX_W + x]     = rgba;
         texel_written[y*TEX_MAX_W + x] = 1'b1;
      end else begin
         expected_colours.push_back(filtered_colour(u, v));
      end
   endtask

   // writes any of the four neighbours not yet loaded
   task automatic cover_footprint(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      int unsigned w, h, tx, ty;
      int unsigned xs [2];
      int unsigned ys [2];
      w = clamp_size(width_reg, TEX_MAX_W);
      h = clamp_size(height_reg, TEX_MAX_H);
      if (w == 0 || h == 0)
         return;
      locate_axis(u, w, xs[0], xs[1], tx);
      locate_axis(v, h, ys[0], ys[1], ty);
      foreach (ys[j])
         foreach (xs[i])
            if (!texel_written[ys[j]*TEX_MAX_W + xs[i]])
               send_request(bts_pkg::OP_WRITE, TEXEL_X_W'(xs[i]), TEXEL_Y_W'(ys[j]),
                            pick_rgba(), pick_coord(), pick_coord());
   endtask

   task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      cover_footprint(u, v);
      send_request(bts_pkg::OP_SAMPLE, TEXEL_X_W'($urandom()), TEXEL_Y_W'($urandom()),
                   $urandom(), u, v);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_colours.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         bts_pkg::CSR_TEXTURE_WIDTH:  width_reg  = data[SIZE_W-1:0];
         bts_pkg::CSR_TEXTURE_HEIGHT: height_reg = data[SIZE_W-1:0];
         bts_pkg::CSR_TINT_RGBA:      tint_reg   = data[RGBA_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [RGBA_W-1:0] tint);
      logic [CSR_DATA_W-1:0] data;
      settle();
      data = $urandom();
      data[SIZE_W-1:0] = w;
      write_csr(bts_pkg::CSR_TEXTURE_WIDTH, data);
      data = $urandom();
      data[SIZE_W-1:0] = h;
      write_csr(bts_pkg::CSR_TEXTURE_HEIGHT, data);
      write_csr(bts_pkg::CSR_TINT_RGBA, tint);
   endtask

   task automatic test_reset_defaults();
      send_request(bts_pkg::OP_WRITE, '0, '0, '0, '0, '0);
      send_request(bts_pkg::OP_WRITE, '1, '1, '1, '1, '1);
      sample_at('0, '0);
      sample_at('1, '1);
      sample_at(16'h0123, 16'h7FFF);
   endtask

   task automatic test_zero_size();
      configure('0, SIZE_W'(TEX_MAX_H), '1);
      sample_at(16'h8000, 16'h8000);
      configure(SIZE_W'(TEX_MAX_W), '0, '1);
      sample_at(16'h8000, 16'h8000);
   endtask

   task automatic test_unit_and_oversize();
      configure(SIZE_W'(1), '1, '1);
      write_csr(CSR_UNUSED, $urandom());
      sample_at('1, 16'h8000);
      configure('1, SIZE_W'(1), 32'hFF00_80FF);
      sample_at(16'h4000, '1);
   endtask

   task automatic test_tint();
      configure(SIZE_W'(2), SIZE_W'(2), '0);
      sample_at(16'h8000, 16'h8000);
      configure(SIZE_W'(2), SIZE_W'(2), 32'h80FF_017F);
      sample_at(16'h6000, 16'hA000);
   endtask

   // receiver holds off while the sender keeps sending, then the pipeline drains and more samples follow
   task automatic test_backpressure();
      configure(SIZE_W'(4), SIZE_W'(4), pick_rgba());
      ready_hold_cycles = 80;
      repeat (40) sample_at(pick_coord(), pick_coord());
      settle();
      repeat (20) sample_at(pick_coord(), pick_coord());
   endtask

   task automatic run_scene();
      int unsigned w_span, h_span;
      configure(pick_size(), pick_size(), pick_rgba());
      w_span = clamp_size(width_reg, TEX_MAX_W);
      h_span = clamp_size(height_reg, TEX_MAX_H);
      if (w_span == 0)
         w_span = TEX_MAX_W;
      if (h_span == 0)
         h_span = TEX_MAX_H;
      repeat (SCENE_REQUESTS) begin
         case ($urandom_range(9))
            0, 1, 2: send_request(bts_pkg::OP_WRITE,
                                  TEXEL_X_W'($urandom_range(w_span - 1)),
                                  TEXEL_Y_W'($urandom_range(h_span - 1)),
                                  pick_rgba(), COORD_W'($urandom()), COORD_W'($urandom()));
            3: send_request(bts_pkg::OP_WRITE, TEXEL_X_W'($urandom_range(TEX_MAX_W - 1)),
                            TEXEL_Y_W'($urandom_range(TEX_MAX_H - 1)), pick_rgba(),
                            COORD_W'($urandom()), COORD_W'($urandom()));
            default: sample_at(pick_coord(), pick_coord());
         endcase
      end
   endtask

   task automatic test_random_traffic();
      int send_mix  [4] = '{0, 74, 0, 6};
      int stall_mix [4] = '{0, 0, 74, 6};
      int start;
      foreach (send_mix[p]) begin
         send_idle_pct = send_mix[p];
         rsp_stall_pct = stall_mix[p];
         start = requests_sent;
         while (requests_sent - start < PHASE_REQUESTS)
            run_scene();
      end
   endtask

   initial begin : response_checker
      logic [RGBA_W-1:0] want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_colours.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected response: actual %h", rsp_bus.sample_rgba);
            end else begin
               want = expected_colours.pop_front();
               if (rsp_bus.sample_rgba !== want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("sample_rgba mismatch: expected %h actual %h",
                              want, rsp_bus.sample_rgba);
               end
            end
         end
         if (ready_hold_cycles > 0) begin
            ready_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : stimulus
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= bts_pkg::OP_WRITE;
      req_bus.texel_x    <= '0;
      req_bus.texel_y    <= '0;
      req_bus.texel_rgba <= '0;
      req_bus.u_coord    <= '0;
      req_bus.v_coord    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_size();
      test_unit_and_oversize();
      test_tint();
      test_backpressure();
      test_random_traffic();

      settle();
      if (error_count == 0)
         $display("bilinear_texture_sampler regression: pass");
      else
         $display("bilinear_texture_sampler regression: fail");
      $finish;
   end

endmodule

// ===== bilinear_texture_sampler.f =====
rtl/bts_pkg.sv
rtl/bts_req_if.sv
rtl/bts_rsp_if.sv
rtl/bilinear_texture_sampler.sv
tb/sv/testbench.sv
